### hdl/dks_pkg.sv
// Shared types, codes and helpers for the dictionary index key scan.
package dks_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_WORD_BYTES_DEF = 256;
  localparam int KEY_MAX_BYTES_DEF  = 16;

  // Fixed field widths
  localparam int KEY_LEN_W = 5;
  localparam int MATCH_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;

  // Scan phase codes
  localparam logic [1:0] PH_STOPPED = 2'd0;
  localparam logic [1:0] PH_WORD    = 2'd1;
  localparam logic [1:0] PH_OFFSET  = 2'd2;
  localparam logic [1:0] PH_SIZE    = 2'd3;

  // Finished record status codes
  localparam logic [STATUS_W-1:0] ST_EOF       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

  // Record kinds on tuser
  localparam logic REC_MATCH  = 1'b0;
  localparam logic REC_FINISH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd4;

  // Settings the per-byte step needs
  typedef struct packed {
    logic [KEY_LEN_W-1:0] klen;   // already clamped to the key storage
    logic                 exact;
    logic [MATCH_W-1:0]   max_matches;
  } dks_cfg_t;

  // Scan state apart from the word length
  typedef struct packed {
    logic [1:0]         phase;
    logic               mismatch;
    logic [1:0]         fcnt;
    logic [31:0]        offset;
    logic [31:0]        size;
    logic [31:0]        entry_cnt;
    logic [MATCH_W-1:0] match_cnt;
  } dks_scan_t;

  // Everything one byte produces: an optional match and an optional finish
  typedef struct packed {
    logic                has_match;
    logic                has_fin;
    logic [31:0]         entry_num;
    logic [31:0]         offset;
    logic [31:0]         size;
    logic [MATCH_W-1:0]  total;
    logic [STATUS_W-1:0] status;
  } dks_rec_t;

  // ASCII upper case letters fold to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
  endfunction

endpackage

### hdl/dks_step.sv
// Per-byte scan step: next state and the records one index byte produces.
module dks_step import dks_pkg::*; #(
  parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF,
  parameter int KEY_MAX_BYTES  = KEY_MAX_BYTES_DEF,
  localparam int WL_W = $clog2(MAX_WORD_BYTES + 1),
  localparam int KI_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1
) (
  input  logic [KEY_MAX_BYTES-1:0][7:0] key_i,
  input  dks_cfg_t                      cfg_i,
  input  logic [7:0]                    byte_i,
  input  logic                          start_i,
  input  logic                          end_i,
  input  dks_scan_t                     scan_i,
  input  logic [WL_W-1:0]               wlen_i,
  output dks_scan_t                     scan_o,
  output logic [WL_W-1:0]               wlen_o,
  output dks_rec_t                      rec_o
);

  logic [7:0]      key_sel;
  logic [WL_W-1:0] klen_ext;

  // a start byte is the first of a word, so it meets key byte 0
  assign key_sel  = start_i ? key_i[0] : key_i[wlen_i[KI_W-1:0]];
  assign klen_ext = WL_W'(cfg_i.klen);

  // One byte of the index walked through the entry format
  always_comb begin
    dks_scan_t          s;
    logic [WL_W-1:0]    wl;
    dks_rec_t           r;
    logic               early;
    logic               hit;
    logic [MATCH_W-1:0] mc;

    s     = scan_i;
    wl    = wlen_i;
    r     = '0;
    early = 1'b0;
    hit   = 1'b0;
    mc    = scan_i.match_cnt;

    // restart drops any running scan
    if (start_i) begin
      s.phase     = PH_WORD;
      s.mismatch  = 1'b0;
      s.fcnt      = 2'd0;
      s.offset    = '0;
      s.size      = '0;
      s.entry_cnt = '0;
      s.match_cnt = '0;
      wl          = '0;
      if (!cfg_i.exact && cfg_i.max_matches == '0) begin
        r.has_fin = 1'b1;
        r.status  = ST_LIMIT;
        s.phase   = PH_STOPPED;
        early     = 1'b1;
      end
    end

    if (!early && s.phase != PH_STOPPED) begin
      case (s.phase)
        PH_WORD: begin
          if (byte_i == 8'd0) begin
            if (wl == '0) begin
              r.has_fin = 1'b1;
              r.status  = ST_EMPTY;
              s.phase   = PH_STOPPED;
            end else begin
              s.phase = PH_OFFSET;
              s.fcnt  = 2'd0;
            end
          end else if (wl >= WL_W'(MAX_WORD_BYTES)) begin
            r.has_fin = 1'b1;
            r.status  = ST_TOO_LONG;
            s.phase   = PH_STOPPED;
          end else begin
            if (wl < klen_ext && fold(byte_i) != fold(key_sel)) begin
              s.mismatch = 1'b1;
            end
            wl = wl + WL_W'(1);
          end
        end
        PH_OFFSET: begin
          s.offset = {s.offset[23:0], byte_i};
          if (s.fcnt == 2'd3) begin
            s.fcnt  = 2'd0;
            s.phase = PH_SIZE;
          end else begin
            s.fcnt = s.fcnt + 2'd1;
          end
        end
        default: begin
          // size field; the last byte closes the entry
          if (s.fcnt == 2'd3) begin
            hit = !s.mismatch &&
                  (cfg_i.exact ? (wl == klen_ext) : (wl >= klen_ext));
            r.entry_num = s.entry_cnt;
            r.offset    = s.offset;
            r.size      = {s.size[23:0], byte_i};
            s.entry_cnt = s.entry_cnt + 32'd1;
            s.mismatch  = 1'b0;
            s.fcnt      = 2'd0;
            s.offset    = '0;
            s.size      = '0;
            wl          = '0;
            s.phase     = PH_WORD;
            if (hit) begin
              if (s.match_cnt != {MATCH_W{1'b1}}) begin
                s.match_cnt = s.match_cnt + MATCH_W'(1);
              end
              r.has_match = 1'b1;
              if (cfg_i.exact || s.match_cnt >= cfg_i.max_matches) begin
                r.has_fin = 1'b1;
                r.status  = ST_LIMIT;
                s.phase   = PH_STOPPED;
              end
            end else begin
              r.entry_num = '0;
              r.offset    = '0;
              r.size      = '0;
            end
          end else begin
            s.size = {s.size[23:0], byte_i};
            s.fcnt = s.fcnt + 2'd1;
          end
        end
      endcase

      // end of file while the scan still runs
      if (end_i && s.phase != PH_STOPPED) begin
        r.has_fin = 1'b1;
        r.status  = (s.phase == PH_WORD && wl == '0) ? ST_EOF : ST_TRUNCATED;
        s.phase   = PH_STOPPED;
      end
    end

    mc      = s.match_cnt;
    r.total = mc;
    scan_o  = s;
    wlen_o  = wl;
    rec_o   = r;
  end

endmodule

### hdl/dictionary_index_key_scan.sv
// Top level of the dictionary index key scan: config, scan state, result queue.
//
// Takes a dictionary index file one byte per word and reports entries whose word
// matches the configured key (ASCII letters compared without case), then one
// finished record with a status. Every accepted byte is handled in the cycle it is
// taken, so the input runs at one byte per clock until the queue fills; the byte
// that closes a matching entry may produce a match record and a finished record,
// which leave the output one word per cycle when not stalled. Results wait in a
// two-entry queue of per-byte results, so the input keeps flowing while the output
// stalls, and s_axis_tready_o drops only when both entries are held. Registers are
// set via the always-ready cfg port; write them only while no scan output is due.
module dictionary_index_key_scan import dks_pkg::*; #(
  parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF,
  parameter int KEY_MAX_BYTES  = KEY_MAX_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  // index bytes in
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // index_byte
  input  logic                 s_axis_tuser_i,   // start_of_index
  input  logic                 s_axis_tlast_i,   // end_of_index
  // records out
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // entry_number[31:0], data_offset[63:32], data_size[95:64],
  // match_total[111:96], scan_status[114:112], zero pad[119:115]
  output logic [119:0]         m_axis_tdata_o,
  output logic                 m_axis_tuser_o,   // record_kind
  output logic                 m_axis_tlast_o    // last_of_run
);

  localparam int WL_W = $clog2(MAX_WORD_BYTES + 1);

  // configuration registers
  logic [KEY_MAX_BYTES-1:0][7:0] key_q;
  logic [KEY_LEN_W-1:0]          key_len_q;
  logic                          exact_q;
  logic [MATCH_W-1:0]            max_q;
  dks_cfg_t                      cfg;

  // scan state
  dks_scan_t       scan_q, scan_d;
  logic [WL_W-1:0] wlen_q, wlen_d;
  dks_rec_t        step_rec;

  // result queue
  dks_rec_t   rec_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       second_q;
  dks_rec_t   head;
  logic       in_fire, push, out_fire, pop, show_match;

  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= KEY_LEN_W'(1);
      exact_q   <= 1'b0;
      max_q     <= MATCH_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW: begin
          for (int i = 0; i < KEY_MAX_BYTES; i++) begin
            if (i < 8) key_q[i] <= cfg_data_i[8*(i%8) +: 8];
          end
        end
        CFG_KEY_HIGH: begin
          for (int i = 0; i < KEY_MAX_BYTES; i++) begin
            if (i >= 8) key_q[i] <= cfg_data_i[8*(i%8) +: 8];
          end
        end
        CFG_KEY_LEN: key_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        CFG_EXACT:   exact_q   <= cfg_data_i[0];
        CFG_MAX:     max_q     <= cfg_data_i[MATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // key lengths beyond the stored key count as the full key
  assign cfg.klen = (key_len_q > KEY_LEN_W'(KEY_MAX_BYTES)) ?
                    KEY_LEN_W'(KEY_MAX_BYTES) : key_len_q;
  assign cfg.exact       = exact_q;
  assign cfg.max_matches = max_q;

  dks_step #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES),
    .KEY_MAX_BYTES  (KEY_MAX_BYTES)
  ) u_step (
    .key_i   (key_q),
    .cfg_i   (cfg),
    .byte_i  (s_axis_tdata_i),
    .start_i (s_axis_tuser_i),
    .end_i   (s_axis_tlast_i),
    .scan_i  (scan_q),
    .wlen_i  (wlen_q),
    .scan_o  (scan_d),
    .wlen_o  (wlen_d),
    .rec_o   (step_rec)
  );

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign push            = in_fire && (step_rec.has_match || step_rec.has_fin);

  // scan state advances on every accepted byte; all zero is the stopped phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      wlen_q <= '0;
    end else if (in_fire) begin
      scan_q <= scan_d;
      wlen_q <= wlen_d;
    end
  end

  // output side: a queue entry gives one or two words
  assign head            = rec_q[rd_q];
  assign show_match      = head.has_match && !second_q;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tuser_o  = show_match ? REC_MATCH : REC_FINISH;
  assign m_axis_tlast_o  = show_match ? !head.has_fin : 1'b1;
  assign m_axis_tdata_o  = show_match ?
      {5'd0, ST_EOF, head.total, head.size, head.offset, head.entry_num} :
      {5'd0, head.status, head.total, 96'd0};
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign pop      = out_fire && m_axis_tlast_o;

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) rec_q[wr_q] <= step_rec;
  end

  // queue pointers and the second-word flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= 1'b0;
      rd_q     <= 1'b0;
      cnt_q    <= 2'd0;
      second_q <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
      if (out_fire) second_q <= !m_axis_tlast_o;
    end
  end

  // the second word of an entry only follows a match that also finished
  a_second_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (cnt_q != 2'd0 && head.has_match && head.has_fin))
    else $error("second word flag set without a two-word entry");

  // a stopped scan ignores bytes without a start mark
  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && scan_q.phase == PH_STOPPED && !s_axis_tuser_i) |=>
      (scan_q.phase == PH_STOPPED && $stable(scan_q.entry_cnt) &&
       $stable(scan_q.match_cnt)))
    else $error("stopped scan changed state");

  // the word length never passes the word size limit
  a_wlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wlen_q <= WL_W'(MAX_WORD_BYTES))
    else $error("word length beyond limit");

  // queue occupancy stays within its two entries
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |=> (cnt_q != 2'd3))
    else $error("result queue overflow");

endmodule
